[src/mfv_pkg.sv]
package mfv_pkg;

  localparam int TABLE_ENTRIES = 64;
  localparam int VALUE_BITS    = 32;
  localparam int COUNT_BITS    = 16;
  localparam int IDX_BITS      = $clog2(TABLE_ENTRIES);
  localparam int USED_BITS     = $clog2(TABLE_ENTRIES + 1);

  typedef logic [VALUE_BITS-1:0] value_t;
  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [IDX_BITS-1:0]   idx_t;
  typedef logic [USED_BITS-1:0]  used_t;

  typedef struct packed {
    logic [31:0] element;
    logic        no_element;
    logic        last;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [31:0] mode_value;
    logic [15:0] mode_count;
    logic [6:0]  distinct_count;
    logic        table_overflow;
  } out_t;

  typedef struct packed {
    logic   valid;
    value_t value;
    count_t count;
  } entry_t;

  typedef struct packed {
    logic count_en;
    logic shift;
  } cell_ctrl_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_SCAN,
    ST_DONE
  } state_e;

  function automatic value_t to_value(logic [31:0] e);
    logic [63:0] t;
    t = 64'(e);
    return t[VALUE_BITS-1:0];
  endfunction

  function automatic logic [31:0] value_to_field(value_t v);
    logic [63:0] t;
    t = 64'(v);
    return t[31:0];
  endfunction

  function automatic logic [15:0] count_to_field(count_t c);
    logic [63:0] t;
    t = 64'(c);
    return t[15:0];
  endfunction

  function automatic logic [6:0] used_to_field(used_t u);
    logic [63:0] t;
    t = 64'(u);
    return t[6:0];
  endfunction

endpackage

[src/mfv_cell.sv]
module mfv_cell
  import mfv_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cell_ctrl_t ctrl_i,
  input  value_t     elem_i,
  input  logic       hit_any_i,
  input  logic       prev_valid_i,
  input  entry_t     next_i,
  output entry_t     entry_o,
  output logic       hit_o
);

  logic   valid_q, valid_d;
  value_t value_q, value_d;
  count_t count_q, count_d;
  logic   take_new;

  assign hit_o    = valid_q && (value_q == elem_i);
  assign take_new = ctrl_i.count_en && !valid_q && prev_valid_i && !hit_any_i;

  always_comb begin
    valid_d = valid_q;
    value_d = value_q;
    count_d = count_q;
    if (ctrl_i.shift) begin
      valid_d = next_i.valid;
      value_d = next_i.value;
      count_d = next_i.count;
    end else if (take_new) begin
      valid_d = 1'b1;
      value_d = elem_i;
      count_d = count_t'(1);
    end else if (ctrl_i.count_en && hit_o && (count_q != '1)) begin
      count_d = count_q + count_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
    count_q <= count_d;
  end

  assign entry_o = '{valid: valid_q, value: value_q, count: count_q};

endmodule

[src/mfv_scan.sv]
module mfv_scan
  import mfv_pkg::*;
(
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   clear_i,
  input  logic   take_i,
  input  entry_t cand_i,
  output value_t best_value_o,
  output count_t best_count_o
);

  value_t best_value_q, best_value_d;
  count_t best_count_q, best_count_d;

  always_comb begin
    best_value_d = best_value_q;
    best_count_d = best_count_q;
    if (clear_i) begin
      best_value_d = '0;
      best_count_d = '0;
    end else if (take_i && cand_i.valid && (cand_i.count > best_count_q)) begin
      // strict compare keeps the earliest first-seen value on a tie
      best_value_d = cand_i.value;
      best_count_d = cand_i.count;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_value_q <= '0;
      best_count_q <= '0;
    end else begin
      best_value_q <= best_value_d;
      best_count_q <= best_count_d;
    end
  end

  assign best_value_o = best_value_q;
  assign best_count_o = best_count_q;

endmodule

[src/most_frequent_value_finder.sv]
// items without last are accepted back to back
// an item with last starts a sweep that shifts the cell row into the max tracker,
// one cell per cycle, across all TABLE_ENTRIES cells; the result is then loaded into the
// output register once the output slot is free; the sweep also clears the row
// reset empties every cell and the output register; no clearing pass is needed
module most_frequent_value_finder
  import mfv_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  state_e     state_q, state_d;
  idx_t       cnt_q, cnt_d;
  used_t      used_q, used_d;
  logic       ovf_q, ovf_d;
  logic       out_valid_q, out_valid_d;
  out_t       out_data_q, out_data_d;

  cell_ctrl_t ctrl;
  value_t     elem;
  entry_t     entries [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] hits;
  logic       hit_any;
  logic       in_acc;
  logic       slot_free;
  logic       clear_best;
  value_t     best_value;
  count_t     best_count;

  assign elem      = to_value(in_data_i.element);
  assign in_acc    = in_valid_i && in_ready_o;
  assign hit_any   = |hits;
  assign slot_free = !out_valid_q || out_ready_i;

  for (genvar i = 0; i < TABLE_ENTRIES; i++) begin : g_cell
    entry_t nxt;
    logic   prev_valid;
    if (i == TABLE_ENTRIES - 1) begin : g_tail
      assign nxt = '0;
    end else begin : g_mid
      assign nxt = entries[i+1];
    end
    if (i == 0) begin : g_head
      assign prev_valid = 1'b1;
    end else begin : g_body
      assign prev_valid = entries[i-1].valid;
    end
    mfv_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .ctrl_i      (ctrl),
      .elem_i      (elem),
      .hit_any_i   (hit_any),
      .prev_valid_i(prev_valid),
      .next_i      (nxt),
      .entry_o     (entries[i]),
      .hit_o       (hits[i])
    );
  end

  mfv_scan u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .clear_i     (clear_best),
    .take_i      (ctrl.shift),
    .cand_i      (entries[0]),
    .best_value_o(best_value),
    .best_count_o(best_count)
  );

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN: begin
        if (in_valid_i && in_data_i.last) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == idx_t'(TABLE_ENTRIES - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_d = ST_RUN;
        end
      end
      default: state_d = ST_RUN;
    endcase
  end

  always_comb begin
    in_ready_o    = 1'b0;
    ctrl.count_en = 1'b0;
    ctrl.shift    = 1'b0;
    clear_best    = 1'b0;
    cnt_d         = cnt_q;
    used_d        = used_q;
    ovf_d         = ovf_q;
    out_valid_d   = out_valid_q && !out_ready_i;
    out_data_d    = out_data_q;
    case (state_q)
      ST_RUN: begin
        in_ready_o    = 1'b1;
        ctrl.count_en = in_valid_i && !in_data_i.no_element;
        cnt_d         = '0;
        if (ctrl.count_en && !hit_any) begin
          if (entries[TABLE_ENTRIES-1].valid) begin
            ovf_d = 1'b1;
          end else begin
            used_d = used_q + used_t'(1);
          end
        end
        if (in_acc && in_data_i.last) begin
          clear_best = 1'b1;
        end
      end
      ST_SCAN: begin
        ctrl.shift = 1'b1;
        cnt_d      = cnt_q + idx_t'(1);
      end
      ST_DONE: begin
        if (slot_free) begin
          out_valid_d                = 1'b1;
          out_data_d.found           = (used_q != '0);
          out_data_d.mode_value      = value_to_field(best_value);
          out_data_d.mode_count      = count_to_field(best_count);
          out_data_d.distinct_count  = used_to_field(used_q);
          out_data_d.table_overflow  = ovf_q;
          used_d                     = '0;
          ovf_d                      = 1'b0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_RUN;
      cnt_q       <= '0;
      used_q      <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      used_q      <= used_d;
      ovf_q       <= ovf_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

[verif/tb_most_frequent_value_finder.sv]
`timescale 1ns / 100ps

module tb_most_frequent_value_finder;
  import mfv_pkg::*;

  localparam int CYCLE_LIMIT  = 3_000_000;
  localparam int RANDOM_BEATS = 1350;
  localparam int SETTLE_CYCLES = TABLE_ENTRIES + 16;
  localparam int PLAN_ROWS    = 21;

  typedef struct packed {
    in_t  beat;
    logic typed;
    out_t want;
  } plan_row_t;

  localparam out_t NO_MODE = '0;

  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{'{32'h0000_0000, 1'b1, 1'b1}, 1'b1, '{1'b0, 32'h0000_0000, 16'd0, 7'd0, 1'b0}},
    '{'{32'hFFFF_FFFF, 1'b0, 1'b1}, 1'b1, '{1'b1, 32'hFFFF_FFFF, 16'd1, 7'd1, 1'b0}},
    '{'{32'h0000_0000, 1'b0, 1'b1}, 1'b1, '{1'b1, 32'h0000_0000, 16'd1, 7'd1, 1'b0}},
    '{'{32'h0000_0005, 1'b0, 1'b0}, 1'b0, NO_MODE},
    '{'{32'h0000_0007, 1'b0, 1'b0}, 1'b0, NO_MODE},
    '{'{32'h0000_0007, 1'b0, 1'b0}, 1'b0, NO_MODE},
    '{'{32'h0000_0005, 1'b0, 1'b0}, 1'b0, NO_MODE},
    '{'{32'h0000_0000, 1'b1, 1'b1}, 1'b0, NO_MODE},
    '{'{32'h0000_0001, 1'b0, 1'b0}, 1'b0, NO_MODE},
    '{'{32'h0000_0002, 1'b0, 1'b0}, 1'b0, NO_MODE},
    '{'{32'h0000_0002, 1'b0, 1'b0}, 1'b0, NO_MODE},
    '{'{32'h0000_0002, 1'b0, 1'b1}, 1'b0, NO_MODE},
    '{'{32'h0000_007B, 1'b1, 1'b0}, 1'b0, NO_MODE},
    '{'{32'hFFFF_FFFF, 1'b1, 1'b1}, 1'b1, '{1'b0, 32'h0000_0000, 16'd0, 7'd0, 1'b0}},
    '{'{32'hAAAA_AAAA, 1'b0, 1'b0}, 1'b0, NO_MODE},
    '{'{32'h5555_5555, 1'b0, 1'b0}, 1'b0, NO_MODE},
    '{'{32'h5555_5555, 1'b0, 1'b0}, 1'b0, NO_MODE},
    '{'{32'h8000_0000, 1'b0, 1'b0}, 1'b0, NO_MODE},
    '{'{32'h7FFF_FFFF, 1'b0, 1'b1}, 1'b0, NO_MODE},
    '{'{32'hFFFF_FFFF, 1'b0, 1'b0}, 1'b0, NO_MODE},
    '{'{32'h0000_0000, 1'b0, 1'b1}, 1'b0, NO_MODE}
  };

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  in_t  in_data_i   = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  out_t out_data_o;

  value_t      tally_vals [TABLE_ENTRIES];
  count_t      tally_cnts [TABLE_ENTRIES];
  int unsigned tally_used = 0;
  bit          tally_ovf  = 1'b0;

  out_t pending_modes[$];
  int   mismatches = 0;
  int   cycles     = 0;
  int   burst_left = 0;

  most_frequent_value_finder i_dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .in_data_i,
    .out_valid_o,
    .out_ready_i,
    .out_data_o
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // frequency table of the current array, first-seen order
  function automatic bit tally_beat(input in_t b, output out_t res);
    value_t v;
    value_t best_val;
    count_t best_cnt;
    bit     hit;
    int     k;
    res = '0;
    if (!b.no_element) begin
      v   = b.element;
      hit = 1'b0;
      for (k = 0; k < tally_used; k++) begin
        if (!hit && tally_vals[idx_t'(k)] == v) begin
          hit = 1'b1;
          if (tally_cnts[idx_t'(k)] != '1) begin
            tally_cnts[idx_t'(k)] = tally_cnts[idx_t'(k)] + count_t'(1);
          end
        end
      end
      if (!hit) begin
        if (tally_used < TABLE_ENTRIES) begin
          tally_vals[idx_t'(tally_used)] = v;
          tally_cnts[idx_t'(tally_used)] = count_t'(1);
          tally_used++;
        end else begin
          tally_ovf = 1'b1;
        end
      end
    end
    if (!b.last) return 1'b0;
    best_val = '0;
    best_cnt = '0;
    for (k = 0; k < tally_used; k++) begin
      if (tally_cnts[idx_t'(k)] > best_cnt) begin
        best_cnt = tally_cnts[idx_t'(k)];
        best_val = tally_vals[idx_t'(k)];
      end
    end
    res.found          = (tally_used != 0);
    res.mode_value     = 32'(best_val);
    res.mode_count     = 16'(best_cnt);
    res.distinct_count = 7'(tally_used);
    res.table_overflow = tally_ovf;
    tally_used = 0;
    tally_ovf  = 1'b0;
    return 1'b1;
  endfunction

  // sender bursts with random gaps; prediction once the beat is taken
  task automatic send_beat(input in_t b, input bit typed, input out_t want);
    out_t res;
    int   gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 20);
    end
    burst_left--;
    in_valid_i <= 1'b1;
    in_data_i  <= b;
    do @(posedge clk_i); while (!in_ready_o);
    if (tally_beat(b, res)) pending_modes.push_back(typed ? want : res);
  endtask

  // receiver stall pattern, switching between four modes
  always @(posedge clk_i) begin
    case (cycles[10:9])
      2'd0: out_ready_i <= 1'b1;
      2'd1: out_ready_i <= ($urandom_range(0, 3) != 0);
      2'd2: out_ready_i <= (cycles[2:0] == 3'd0);
      default: out_ready_i <= (cycles[4:0] < 5'd4);
    endcase
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_modes.size() == 0) begin
        $display("%0t: unexpected beat, expected none, got %p", $time, out_data_o);
        mismatches++;
      end else begin
        want = pending_modes.pop_front();
        if (out_data_o.found !== want.found) begin
          $display("%0t: found expected %0d got %0d", $time, want.found, out_data_o.found);
          mismatches++;
        end
        if (out_data_o.mode_value !== want.mode_value) begin
          $display("%0t: mode_value expected %h got %h", $time, want.mode_value,
                   out_data_o.mode_value);
          mismatches++;
        end
        if (out_data_o.mode_count !== want.mode_count) begin
          $display("%0t: mode_count expected %0d got %0d", $time, want.mode_count,
                   out_data_o.mode_count);
          mismatches++;
        end
        if (out_data_o.distinct_count !== want.distinct_count) begin
          $display("%0t: distinct_count expected %0d got %0d", $time, want.distinct_count,
                   out_data_o.distinct_count);
          mismatches++;
        end
        if (out_data_o.table_overflow !== want.table_overflow) begin
          $display("%0t: table_overflow expected %0d got %0d", $time, want.table_overflow,
                   out_data_o.table_overflow);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    in_t    b;
    value_t pool_vals [128];
    int     n;
    int     k;
    int     r;
    int     len;
    int     psize;
    int     sent;
    bit     sweep;
    bit     narrow;

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (n = 0; n < PLAN_ROWS; n++) begin
      send_beat(PLAN[5'(n)].beat, PLAN[5'(n)].typed, PLAN[5'(n)].want);
    end

    sent = 0;
    while (sent < RANDOM_BEATS) begin
      r = $urandom_range(0, 99);
      if (r < 5) begin
        len = $urandom_range(1, 3);
        for (k = 0; k < len; k++) begin
          send_beat('{$urandom(), 1'b1, k == len - 1}, 1'b0, NO_MODE);
        end
        sent++;
      end else begin
        if (r < 65) begin
          len   = $urandom_range(1, 10);
          psize = $urandom_range(1, len);
          sweep = 1'b0;
        end else if (r < 88) begin
          len   = $urandom_range(11, 40);
          psize = $urandom_range(1, len);
          sweep = ($urandom_range(0, 3) == 0);
        end else begin
          psize = $urandom_range(0, 1) ? TABLE_ENTRIES : $urandom_range(65, 90);
          len   = $urandom_range(psize, 100);
          sweep = ($urandom_range(0, 9) < 7);
        end
        narrow = (len <= 40) && ($urandom_range(0, 9) < 3);
        for (k = 0; k < psize; k++) begin
          pool_vals[7'(k)] = narrow ? value_t'($urandom_range(0, 7)) : value_t'($urandom());
        end
        for (k = 0; k < len; k++) begin
          b.element    = sweep ? pool_vals[7'(k % psize)]
                               : pool_vals[7'($urandom_range(0, psize - 1))];
          b.no_element = ($urandom_range(0, 15) == 0);
          b.last       = (k == len - 1);
          if (b.no_element) b.element = $urandom();
          send_beat(b, 1'b0, NO_MODE);
          if (!b.no_element || b.last) sent++;
        end
      end
    end
    in_valid_i <= 1'b0;

    while (pending_modes.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
